// File: src/spfd_pkg.sv
package spfd_pkg;

  // Pixel depth of the incoming byte stream.
  typedef enum logic [1:0] {
    DEPTH_PAL8   = 2'd0,
    DEPTH_RGB565 = 2'd1,
    DEPTH_BGR24  = 2'd2,
    DEPTH_BGRA32 = 2'd3
  } depth_mode_t;

  // Kind of an input word, carried in bit 0 of in_tuser.
  localparam logic REQ_PALETTE = 1'b0;
  localparam logic REQ_PIXEL   = 1'b1;

  // Register word indexes on the configuration port.
  localparam logic [1:0] REG_DEPTH_MODE   = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam int PALETTE_DEPTH = 256;
  localparam int ARGB_W        = 32;
  localparam int DEST_W        = 20;
  localparam int DIM_W         = 11;

  // Reciprocal constants: v*255/31 = (v*SCALE5_MUL) >> 18 and
  // v*255/63 = (v*SCALE6_MUL) >> 20, exact over the whole input range.
  localparam logic [25:0] SCALE5_MUL = 26'd2156535;
  localparam logic [27:0] SCALE6_MUL = 28'd4244475;

  // Result of the first stage, waiting for the palette read.
  typedef struct packed {
    logic                use_pal;
    logic [ARGB_W-1:0]   argb;
    logic [DEST_W-1:0]   dest;
    logic                last;
  } spfd_pix_t;

  // Expand a five-bit colour field to eight bits.
  function automatic logic [7:0] scale5(input logic [4:0] v);
    logic [25:0] p;
    p = 26'(v) * SCALE5_MUL;
    return p[25:18];
  endfunction

  // Expand a six-bit colour field to eight bits.
  function automatic logic [7:0] scale6(input logic [5:0] v);
    logic [27:0] p;
    p = 28'(v) * SCALE6_MUL;
    return p[27:20];
  endfunction

  // Opaque colour word, except that pure black becomes fully transparent.
  function automatic logic [ARGB_W-1:0] argb_unless_black(input logic [7:0] b,
                                                          input logic [7:0] g,
                                                          input logic [7:0] r);
    logic [ARGB_W-1:0] res;
    if (r == 8'd0 && g == 8'd0 && b == 8'd0) begin
      res = '0;
    end else begin
      res = {8'hFF, r, g, b};
    end
    return res;
  endfunction

endpackage

// File: src/spfd_ram.sv
module spfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/sprite_pixel_format_decoder.sv
// Sprite pixel decoder: raw frame bytes in, ARGB8888 pixels out.
//
// The input stream carries two kinds of word, chosen by in_tuser[0]:
// palette writes (index and blue, green, red) and pixel data bytes. The
// palette is loaded before the pixels that use it; a black entry is stored
// fully transparent. in_tuser[1] on a pixel byte starts a new frame.
// Bytes are gathered little-endian into pixels of the depth set in the
// depth register (8-bit palette, RGB565, BGR24 or BGRA32) and each pixel
// leaves on the output stream with its vertically flipped destination
// index and out_tlast on the final pixel of the frame. Padding bytes of
// 8-bit rows, palette writes and partial pixel bytes give no output word.
// The completing byte's pixel passes the middle stage and then the output
// register; one byte is taken every cycle while the output is not stalled,
// with one palette RAM read per 8-bit pixel. A result waiting at the output
// does not block the input: one more word is taken into the middle stage,
// and only then does in_tready drop until the receiver takes the output.
// Reset empties the pipeline, clears the byte gather and the row and
// column counters and loads the registers with depth 0, width 1 and
// height 1. Palette contents are not cleared and must be written first.
module sprite_pixel_format_decoder #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input words.
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] data_byte, [15:8] pal_index, [23:16] pal_blue, [31:24] pal_green,
  // [39:32] pal_red
  input  logic [39:0] in_tdata,
  // [0] req_type, [1] start_of_frame
  input  logic [1:0]  in_tuser,
  // Output words.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] argb_pixel, [51:32] dest_index, [55:52] zero
  output logic [55:0] out_tdata,
  output logic        out_tlast,
  // Register port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW = $clog2(MAX_WIDTH + 4);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = RW + CW + 1;
  localparam int PAW = $clog2(spfd_pkg::PALETTE_DEPTH);

  // Input fields.
  logic       req_type;
  logic       start_of_frame;
  logic [7:0] data_byte;
  logic [7:0] pal_index;
  logic [7:0] pal_blue;
  logic [7:0] pal_green;
  logic [7:0] pal_red;

  assign req_type       = in_tuser[0];
  assign start_of_frame = in_tuser[1];
  assign data_byte      = in_tdata[7:0];
  assign pal_index      = in_tdata[15:8];
  assign pal_blue       = in_tdata[23:16];
  assign pal_green      = in_tdata[31:24];
  assign pal_red        = in_tdata[39:32];

  // Registers.
  spfd_pkg::depth_mode_t          depth_mode_r;
  logic [spfd_pkg::DIM_W-1:0]     frame_width_r;
  logic [spfd_pkg::DIM_W-1:0]     frame_height_r;

  // Decode state.
  logic [23:0]   gather_r, gather_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  // Pipeline.
  logic                s1_valid_r;
  spfd_pkg::spfd_pix_t s1_r, s1_nxt;
  logic                out_valid_r;
  logic [31:0]         out_argb_r;
  logic [19:0]         out_dest_r;
  logic                out_last_r;

  logic in_accept, pix_accept, pal_accept, advance_out, s1_free;
  logic emit;
  logic cfg_write;

  logic [CW-1:0] w, w_p3, stride, col0, col1, col_inc;
  logic [RW-1:0] h, row0, row1, row2, row_inc, h_rem;
  logic [23:0]   gather0;
  logic [1:0]    phase0;
  logic          complete;
  logic [15:0]   c565;
  logic [31:0]   direct_argb;
  logic [RW+CW-1:0] prod;
  logic [PW-1:0]    dest_full;
  logic [31:0]      pal_rdata;

  // Handshakes.
  assign advance_out = !out_valid_r || out_tready;
  assign s1_free     = !s1_valid_r || advance_out;
  assign in_tready   = s1_free;
  assign in_accept   = in_tvalid && in_tready;
  assign pix_accept  = in_accept && (req_type == spfd_pkg::REQ_PIXEL);
  assign pal_accept  = in_accept && (req_type == spfd_pkg::REQ_PALETTE);

  // Register port.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_mode_r   <= spfd_pkg::DEPTH_PAL8;
      frame_width_r  <= spfd_pkg::DIM_W'(1);
      frame_height_r <= spfd_pkg::DIM_W'(1);
    end else if (cfg_write) begin
      case (cfg_paddr[3:2])
        spfd_pkg::REG_DEPTH_MODE: begin
          depth_mode_r <= spfd_pkg::depth_mode_t'(cfg_pwdata[1:0]);
        end
        spfd_pkg::REG_FRAME_WIDTH: begin
          frame_width_r <= cfg_pwdata[spfd_pkg::DIM_W-1:0];
        end
        spfd_pkg::REG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_pwdata[spfd_pkg::DIM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      spfd_pkg::REG_DEPTH_MODE:   cfg_prdata = {30'd0, depth_mode_r};
      spfd_pkg::REG_FRAME_WIDTH:  cfg_prdata = {21'd0, frame_width_r};
      spfd_pkg::REG_FRAME_HEIGHT: cfg_prdata = {21'd0, frame_height_r};
      default:                    cfg_prdata = '0;
    endcase
  end

  // Frame dimensions, limited to one and the configured maxima.
  always_comb begin
    if (frame_width_r == '0) begin
      w = CW'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h = RW'(1);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      h = RW'(MAX_HEIGHT);
    end else begin
      h = RW'(frame_height_r);
    end
  end

  // 8-bit rows are padded up to a multiple of four bytes.
  assign w_p3   = w + CW'(3);
  assign stride = (depth_mode_r == spfd_pkg::DEPTH_PAL8) ? {w_p3[CW-1:2], 2'b00} : w;

  // Counter and gather update for one pixel byte.
  always_comb begin
    gather0  = start_of_frame ? '0 : gather_r;
    phase0   = start_of_frame ? '0 : phase_r;
    col0     = start_of_frame ? '0 : col_r;
    row0     = start_of_frame ? '0 : row_r;

    // A column left past the row end by a settings change starts a new row.
    if (col0 >= stride) begin
      col1 = '0;
      row1 = row0 + RW'(1);
    end else begin
      col1 = col0;
      row1 = row0;
    end
    row2 = (row1 >= h) ? '0 : row1;

    complete = (phase0 >= 2'(depth_mode_r));
    emit     = complete && ((depth_mode_r != spfd_pkg::DEPTH_PAL8) || (col1 < w));

    col_inc = col1 + CW'(1);
    row_inc = row2 + RW'(1);

    gather_nxt = gather_r;
    phase_nxt  = phase_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (pix_accept) begin
      if (complete) begin
        gather_nxt = '0;
        phase_nxt  = '0;
        if (col_inc >= stride) begin
          col_nxt = '0;
          row_nxt = (row_inc >= h) ? '0 : row_inc;
        end else begin
          col_nxt = col_inc;
          row_nxt = row2;
        end
      end else begin
        case (phase0)
          2'd0:    gather_nxt = gather0 | {16'd0, data_byte};
          2'd1:    gather_nxt = gather0 | {8'd0, data_byte, 8'd0};
          default: gather_nxt = gather0 | {data_byte, 16'd0};
        endcase
        phase_nxt = phase0 + 2'd1;
        col_nxt   = col1;
        row_nxt   = row2;
      end
    end
  end

  // Direct colour conversion of the gathered bytes and the completing byte.
  assign c565 = {data_byte, gather0[7:0]};

  always_comb begin
    case (depth_mode_r)
      spfd_pkg::DEPTH_RGB565: begin
        if (c565 == '0) begin
          direct_argb = '0;
        end else begin
          direct_argb = {8'hFF, spfd_pkg::scale5(c565[15:11]),
                         spfd_pkg::scale6(c565[10:5]), spfd_pkg::scale5(c565[4:0])};
        end
      end
      spfd_pkg::DEPTH_BGR24: begin
        direct_argb = spfd_pkg::argb_unless_black(gather0[7:0], gather0[15:8], data_byte);
      end
      spfd_pkg::DEPTH_BGRA32: begin
        direct_argb = {data_byte, gather0[23:16], gather0[15:8], gather0[7:0]};
      end
      default: begin
        direct_argb = '0;
      end
    endcase
  end

  // Flipped destination index (h-1-row)*w + column.
  assign h_rem     = h - RW'(1) - row2;
  assign prod      = (RW+CW)'(h_rem) * (RW+CW)'(w);
  assign dest_full = PW'(prod) + PW'(col1);

  always_comb begin
    s1_nxt.use_pal = (depth_mode_r == spfd_pkg::DEPTH_PAL8);
    s1_nxt.argb    = direct_argb;
    s1_nxt.dest    = spfd_pkg::DEST_W'(dest_full);
    s1_nxt.last    = (row2 == h - RW'(1)) && (col1 == w - CW'(1));
  end

  // Palette store: written by palette words, read by 8-bit pixel bytes.
  spfd_ram #(
    .WIDTH (spfd_pkg::ARGB_W),
    .DEPTH (spfd_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_accept),
    .waddr (PAW'(pal_index)),
    .wdata (spfd_pkg::argb_unless_black(pal_blue, pal_green, pal_red)),
    .re    (pix_accept && (depth_mode_r == spfd_pkg::DEPTH_PAL8)),
    .raddr (PAW'(data_byte)),
    .rdata (pal_rdata)
  );

  // Decode state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gather_r <= '0;
      phase_r  <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      gather_r <= gather_nxt;
      phase_r  <= phase_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  // Middle stage, aligned with the palette read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= pix_accept && emit;
    end else if (advance_out) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= s1_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance_out) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_out && s1_valid_r) begin
      out_argb_r <= s1_r.use_pal ? pal_rdata : s1_r.argb;
      out_dest_r <= s1_r.dest;
      out_last_r <= s1_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_dest_r, out_argb_r};
  assign out_tlast  = out_last_r;

endmodule

// File: src/spfd_checker.sv
module spfd_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast
);

  // A stalled output word stays offered.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word withdrawn while stalled");

  // A stalled output word keeps its contents.
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A new output word comes from a pixel byte taken through the middle stage and then the output register.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tuser[0], 2))
    else $error("output word without a pixel byte two cycles earlier");

endmodule

bind sprite_pixel_format_decoder spfd_props u_spfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
